FILE: hw/rtl/tkss_pkg.sv
package tkss_pkg;

	localparam int DATA_W = 32;
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W = $clog2(MAX_RESULTS);
	localparam logic [7:0] KEEP_RESET = 8'd100;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DUMP = 1'b1;

	typedef struct packed {
		logic              func;
		logic [DATA_W-1:0] item_id;
		logic [DATA_W-1:0] distance;
	} cand_t;

	typedef struct packed {
		logic              valid_res;
		logic [DATA_W-1:0] out_id;
		logic [DATA_W-1:0] out_distance;
		logic              last;
	} res_t;

	// one held pair
	typedef struct packed {
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] distance;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              shift;
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] distance;
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} st_t;

endpackage

FILE: hw/rtl/top_k_smallest_select_core.sv
// Channel   | Handshake                | Payload            | Direction
// ----------+--------------------------+--------------------+----------
// cand      | cand_valid / cand_stall  | cand (cand_t)      | in
// res       | res_valid  / res_stall   | res (res_t)        | out
// cfg       | cfg_valid  / cfg_ready   | cfg_data (8 bits)  | in
//
// Insert: one transfer per cycle while no dump runs; the sorted cell chain registers it directly.
// Dump of n pairs (n <= 64, an empty dump counts as one result): cand stays stalled from
//   its transfer until the last result is registered, one result per cycle from the head cell
//   while res is not stalled; a stalled result holds the dump.
// Reset clears all cell valid bits (store empty) and sets k to 100.
// res has an output register: a stalled result holds, the chain waits.
module top_k_smallest_select_core #(
	parameter int MAX_KEEP = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cand_valid,
	output logic            cand_stall,
	input  tkss_pkg::cand_t cand,
	output logic            res_valid,
	input  logic            res_stall,
	output tkss_pkg::res_t  res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_data
);
	import tkss_pkg::*;

	// keep count register; k = 0 acts as 1 (cell 0 always enabled)
	logic [7:0] keep_q;
	st_t st_q, st_nxt;
	logic [CNT_W-1:0] emit_cnt_q;
	logic res_valid_q;
	res_t res_q;

	// chain wiring, one extra slot past the tail that reads empty
	logic   cell_v [MAX_KEEP+1];
	entry_t cell_e [MAX_KEEP+1];
	logic   cell_keep [MAX_KEEP];
	logic   cell_en [MAX_KEEP];

	cell_op_t op;
	logic cand_xfer, take, dump_go, emit_end;

	assign cand_xfer = cand_valid && !cand_stall;
	assign take = !res_valid_q || !res_stall;
	assign dump_go = (st_q == ST_DUMP) && take;
	// dump ends at empty store, at the last held pair, or at the result limit
	assign emit_end = dump_go && (!cell_v[0] || !cell_v[1] ||
		(emit_cnt_q == CNT_W'(MAX_RESULTS - 1)));

	assign cell_v[MAX_KEEP] = 1'b0;
	assign cell_e[MAX_KEEP] = '0;

	always_comb begin
		op.ins      = cand_xfer && (cand.func == FUNC_INSERT);
		op.shift    = dump_go && cell_v[0];
		op.id       = cand.item_id;
		op.distance = cand.distance;
	end

	genvar i;
	generate
		for (i = 0; i < MAX_KEEP; i++) begin : g_cell
			// cells at or beyond k never hold a pair; the overflow falls off there
			assign cell_en[i] = (i == 0) || (i < int'(keep_q));
			if (i == 0) begin : g_head
				tkss_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.op        (op),
					.en        (cell_en[i]),
					.prev_v    (1'b0),
					.prev_e    ('0),
					.prev_keep (1'b1),
					.next_v    (cell_v[i+1]),
					.next_e    (cell_e[i+1]),
					.v         (cell_v[i]),
					.e         (cell_e[i]),
					.keep      (cell_keep[i])
				);
			end else begin : g_body
				tkss_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.op        (op),
					.en        (cell_en[i]),
					.prev_v    (cell_v[i-1]),
					.prev_e    (cell_e[i-1]),
					.prev_keep (cell_keep[i-1]),
					.next_v    (cell_v[i+1]),
					.next_e    (cell_e[i+1]),
					.v         (cell_v[i]),
					.e         (cell_e[i]),
					.keep      (cell_keep[i])
				);
			end
		end
	endgenerate

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (cand_xfer && (cand.func == FUNC_DUMP)) begin
					st_nxt = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (emit_end) begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cand_stall = 1'b0;
		unique case (st_q)
			ST_IDLE: cand_stall = 1'b0;
			ST_DUMP: cand_stall = 1'b1;
			default: cand_stall = 1'b1;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			keep_q      <= KEEP_RESET;
			emit_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			// k only changes while the store is empty
			if (cfg_valid && cfg_ready && !cell_v[0]) begin
				keep_q <= cfg_data;
			end
			if (dump_go) begin
				emit_cnt_q <= emit_end ? '0 : emit_cnt_q + 1'b1;
			end
			if (dump_go) begin
				res_valid_q <= 1'b1;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// head cell goes out; empty store gives a blank result marked last
	always_ff @(posedge clk) begin
		if (dump_go) begin
			res_q.valid_res    <= cell_v[0];
			res_q.out_id       <= cell_v[0] ? cell_e[0].id : '0;
			res_q.out_distance <= cell_v[0] ? cell_e[0].distance : '0;
			res_q.last         <= !cell_v[0] || !cell_v[1];
		end
	end

	a_dump_blocks_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DUMP) |-> cand_stall)
		else $error("candidate accepted during dump");

	a_head_empties_only_by_dump: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cell_v[0]) |-> $past(st_q == ST_DUMP))
		else $error("store emptied outside dump");

	a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (emit_cnt_q == '0))
		else $error("emit counter not cleared");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(dump_go && cell_v[0] && !cell_v[1]) |=> !cell_v[0])
		else $error("store not empty after last result");

	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[1] |-> cell_v[0])
		else $error("hole at head of cell chain");

endmodule

FILE: hw/rtl/tkss_cell.sv
module tkss_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tkss_pkg::cell_op_t op,
	input  logic              en,
	input  logic              prev_v,
	input  tkss_pkg::entry_t  prev_e,
	input  logic              prev_keep,
	input  logic              next_v,
	input  tkss_pkg::entry_t  next_e,
	output logic              v,
	output tkss_pkg::entry_t  e,
	output logic              keep
);
	import tkss_pkg::*;

	logic v_q;
	entry_t e_q;

	// ties stay put: newcomer goes after equal distances
	assign keep = v_q && (e_q.distance <= op.distance);
	assign v = v_q;
	assign e = e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (op.shift) begin
			v_q <= next_v;
		end else if (op.ins) begin
			if (!en) begin
				v_q <= 1'b0;
			end else if (!keep) begin
				v_q <= prev_keep ? 1'b1 : prev_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.shift) begin
			e_q <= next_e;
		end else if (op.ins && en && !keep) begin
			if (prev_keep) begin
				e_q.id       <= op.id;
				e_q.distance <= op.distance;
			end else begin
				e_q <= prev_e;
			end
		end
	end

endmodule

FILE: test/top_k_smallest_select_core_tb.sv
module top_k_smallest_select_core_tb;
	import tkss_pkg::*;

	localparam int KEEP_MAX = 128;
	localparam int CLK_PERIOD = 4;
	localparam int SETTLE = 4;             // margin after an insert is absorbed
	localparam int LIMIT_CYCLES = 400000;
	localparam res_t EMPTY_DUMP = '{valid_res: 1'b0, out_id: '0, out_distance: '0, last: 1'b1};

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_t;

	// one row of the directed plan: either a keep_count write or a cand transfer
	typedef struct {
		bit         is_cfg;
		logic [7:0] keep;
		cand_t      item;
		bit         typed;
		res_t       want;
	} step_t;

	typedef struct {
		logic [7:0] keep;
		idle_t      mode;
		int         items;
		int         dump_pct;
		bit         flush;
	} phase_t;

	logic       clk;
	logic       arst_n;
	logic       cand_valid;
	logic       cand_stall;
	cand_t      cand;
	logic       res_valid;
	logic       res_stall;
	res_t       res;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	// shadow of the selector: sorted ascending by distance, ties in arrival order
	logic [31:0] store_id [KEEP_MAX];
	logic [31:0] store_dist [KEEP_MAX];
	int          store_cnt;
	logic [7:0]  keep_reg;
	res_t        due_res [$];

	idle_t idle_mode;
	int    errors;
	int    n_items;
	int    n_dumps;
	int    n_partial;
	int    n_results;
	int    n_cfg;

	top_k_smallest_select_core #(
		.MAX_KEEP(KEEP_MAX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand_valid(cand_valid),
		.cand_stall(cand_stall),
		.cand      (cand),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("top_k_smallest_select_core_tb NOT OK");
		$finish;
	end

	function automatic int send_pct();
		case (idle_mode)
			IDLE_SEND: return 57;
			IDLE_BOTH: return 14;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_pct();
		case (idle_mode)
			IDLE_RECV: return 57;
			IDLE_BOTH: return 14;
			default:   return 0;
		endcase
	endfunction

	// effective k: register clamped to 1..KEEP_MAX
	function automatic int keep_limit();
		int k;
		k = int'(keep_reg);
		if (k < 1) k = 1;
		if (k > KEEP_MAX) k = KEEP_MAX;
		return k;
	endfunction

	function automatic void predict_transfer(cand_t c);
		int   k;
		int   pos;
		int   n;
		res_t r;
		if (c.func == FUNC_INSERT) begin
			k = keep_limit();
			if (store_cnt > k) store_cnt = k;
			pos = 0;
			// first slot strictly larger, so equal distances keep arrival order
			while (pos < store_cnt && store_dist[pos] <= c.distance) pos++;
			if (store_cnt < k) begin
				for (int i = store_cnt; i > pos; i--) begin
					store_id[i] = store_id[i - 1];
					store_dist[i] = store_dist[i - 1];
				end
				store_id[pos] = c.item_id;
				store_dist[pos] = c.distance;
				store_cnt++;
			end else if (pos < store_cnt) begin
				// full: the tail entry falls off
				for (int i = store_cnt - 1; i > pos; i--) begin
					store_id[i] = store_id[i - 1];
					store_dist[i] = store_dist[i - 1];
				end
				store_id[pos] = c.item_id;
				store_dist[pos] = c.distance;
			end
			// full and no larger entry: newcomer is dropped
		end else if (store_cnt == 0) begin
			due_res.insert(due_res.size(), EMPTY_DUMP);
		end else begin
			n = (store_cnt > MAX_RESULTS) ? MAX_RESULTS : store_cnt;
			for (int i = 0; i < n; i++) begin
				r.valid_res = 1'b1;
				r.out_id = store_id[i];
				r.out_distance = store_dist[i];
				r.last = (i + 1 == store_cnt);
				due_res.insert(due_res.size(), r);
			end
			for (int i = n; i < store_cnt; i++) begin
				store_id[i - n] = store_id[i];
				store_dist[i - n] = store_dist[i];
			end
			if (n < store_cnt) n_partial++;
			store_cnt -= n;
		end
	endfunction

	task automatic note_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_result(res_t got, res_t want);
		if (got.valid_res !== want.valid_res)
			note_mismatch($sformatf("valid_res %0b want %0b", got.valid_res, want.valid_res));
		if (got.out_id !== want.out_id)
			note_mismatch($sformatf("out_id %h want %h", got.out_id, want.out_id));
		if (got.out_distance !== want.out_distance)
			note_mismatch($sformatf("out_distance %h want %h", got.out_distance,
				want.out_distance));
		if (got.last !== want.last)
			note_mismatch($sformatf("last %0b want %0b", got.last, want.last));
	endtask

	// receiver side: random stall per cycle, rate set by the current phase
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_pct());
	end

	// every accepted result is matched against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (due_res.size() == 0)
				note_mismatch($sformatf("result with none pending: id %h dist %h",
					res.out_id, res.out_distance));
			else
				check_result(res, due_res.pop_front());
		end
	end

	// Called at a clock edge. Valid stays high from one transfer to the next unless
	// a gap is rolled, so it is never lowered and raised in the same step.
	task automatic send_item(cand_t c, bit typed, res_t want);
		int gap;
		int before_cnt;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < send_pct()) gap++;
		if (gap != 0) begin
			cand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand_valid <= 1'b1;
		cand <= c;
		@(posedge clk);
		while (cand_stall) @(posedge clk);
		before_cnt = due_res.size();
		predict_transfer(c);
		if (typed) begin
			// hand-written expectation replaces the predicted one
			while (due_res.size() > before_cnt) void'(due_res.pop_back());
			due_res.insert(due_res.size(), want);
		end
		n_items++;
		if (c.func == FUNC_DUMP) n_dumps++;
	endtask

	// keep_count is only touched with the block quiet
	task automatic write_keep(logic [7:0] k);
		cand_valid <= 1'b0;
		while (due_res.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (store_cnt == 0) keep_reg = k;
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	function automatic step_t ins_row(logic [31:0] id, logic [31:0] d);
		step_t s;
		s = '{is_cfg: 1'b0, keep: '0, item: '0, typed: 1'b0, want: '0};
		s.item.func = FUNC_INSERT;
		s.item.item_id = id;
		s.item.distance = d;
		return s;
	endfunction

	// typed: store known empty, so the single result is read off directly
	function automatic step_t dump_row(bit typed);
		step_t s;
		s = '{is_cfg: 1'b0, keep: '0, item: '0, typed: typed, want: EMPTY_DUMP};
		s.item.func = FUNC_DUMP;
		return s;
	endfunction

	function automatic step_t keep_row(logic [7:0] k);
		step_t s;
		s = '{is_cfg: 1'b1, keep: k, item: '0, typed: 1'b0, want: '0};
		return s;
	endfunction

	function automatic logic [31:0] rand_dist();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $urandom_range(0, 15);               // dense, lots of ties
			2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return 32'h0100_0000 + $urandom_range(0, 255);  // near 1.0
		endcase
	endfunction

	function automatic cand_t rand_cand(bit dump);
		cand_t c;
		c.func = dump ? FUNC_DUMP : FUNC_INSERT;
		c.item_id = $urandom;
		c.distance = rand_dist();
		return c;
	endfunction

	initial begin
		step_t  plan [$];
		phase_t phases [$];
		arst_n = 1'b0;
		cand_valid = 1'b0;
		cand = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		store_cnt = 0;
		keep_reg = KEEP_RESET;
		idle_mode = IDLE_NONE;
		errors = 0;
		n_items = 0;
		n_dumps = 0;
		n_partial = 0;
		n_results = 0;
		n_cfg = 0;

		// directed: reset k, extremes, ties, full store, ignored write
		plan.insert(plan.size(), dump_row(1'b1));
		plan.insert(plan.size(), ins_row(32'h0000_0000, 32'hFFFF_FFFF));
		plan.insert(plan.size(), ins_row(32'hFFFF_FFFF, 32'h0000_0000));
		plan.insert(plan.size(), ins_row(32'h0000_0001, 32'h0100_0000));
		plan.insert(plan.size(), ins_row(32'h0000_0002, 32'h0100_0000));
		plan.insert(plan.size(), ins_row(32'h0000_0003, 32'hFFFF_FFFF));
		plan.insert(plan.size(), dump_row(1'b0));
		plan.insert(plan.size(), dump_row(1'b1));
		plan.insert(plan.size(), keep_row(8'd2));
		plan.insert(plan.size(), ins_row(32'h0000_000A, 32'h0000_0005));
		plan.insert(plan.size(), ins_row(32'h0000_000B, 32'h0000_0005));
		plan.insert(plan.size(), ins_row(32'h0000_000C, 32'h0000_0005));  // ties the max while full
		plan.insert(plan.size(), ins_row(32'h0000_000D, 32'h0000_0004));
		plan.insert(plan.size(), ins_row(32'h0000_000E, 32'hFFFF_FFFF));
		plan.insert(plan.size(), keep_row(8'd9));                         // store not empty
		plan.insert(plan.size(), ins_row(32'hA5A5_5A5A, 32'h0000_0000));
		plan.insert(plan.size(), dump_row(1'b0));
		plan.insert(plan.size(), dump_row(1'b1));

		// random: out-of-range k both ways, a long dump, a write held off, k=128
		phases.insert(phases.size(), phase_t'{8'd0,   IDLE_NONE,  5, 30, 1'b1});
		phases.insert(phases.size(), phase_t'{8'd255, IDLE_RECV, 66,  0, 1'b1});
		phases.insert(phases.size(), phase_t'{8'd1,   IDLE_SEND,  5, 20, 1'b0});
		phases.insert(phases.size(), phase_t'{8'd7,   IDLE_BOTH,  5, 25, 1'b1});
		phases.insert(phases.size(), phase_t'{8'd3,   IDLE_RECV,  5, 30, 1'b1});
		phases.insert(phases.size(), phase_t'{8'd128, IDLE_BOTH,  5, 20, 1'b1});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_keep(plan[i].keep);
			else
				send_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		foreach (phases[p]) begin
			write_keep(phases[p].keep);
			idle_mode = phases[p].mode;
			for (int i = 0; i < phases[p].items; i++)
				send_item(rand_cand($urandom_range(0, 99) < phases[p].dump_pct), 1'b0, EMPTY_DUMP);
			if (phases[p].flush) begin
				while (store_cnt != 0) send_item(rand_cand(1'b1), 1'b0, EMPTY_DUMP);
			end
		end

		cand_valid <= 1'b0;
		while (due_res.size() != 0) @(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);

		$display("%0d cand transfers (%0d dumps, %0d cut short at %0d), %0d results checked",
			n_items, n_dumps, n_partial, MAX_RESULTS, n_results);
		$display("%0d keep_count writes: reset value, 0, 1, 2, 3, 128, 255, one on a held store",
			n_cfg);
		if (errors == 0)
			$display("top_k_smallest_select_core_tb OK");
		else
			$display("top_k_smallest_select_core_tb NOT OK");
		$finish;
	end

endmodule
